FILE: hw/rtl/epc_pkg.sv
// Shared types and constants of the edge pair page cache.
package epc_pkg;

	// Cache geometry, fixed by the field widths of the transactions.
	localparam int CACHE_SLOTS = 16;
	localparam int PAGE_BITS   = 16;
	localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

	// Request transaction: the two pages touched by one edge access.
	typedef struct packed {
		logic [PAGE_BITS-1:0] src_page;
		logic [PAGE_BITS-1:0] dst_page;
	} req_t;

	// Response transaction: outcome, loads made and running load total.
	typedef struct packed {
		logic [1:0]           outcome;
		logic [1:0]           pages_loaded;
		logic [PAGE_BITS-1:0] first_page;
		logic [SLOT_W-1:0]    first_slot;
		logic [PAGE_BITS-1:0] second_page;
		logic [SLOT_W-1:0]    second_slot;
		logic                 skipped;
		logic [31:0]          total_loads;
	} rsp_t;

	// Outcome codes.
	localparam logic [1:0] OC_BOTH_HIT = 2'd0;
	localparam logic [1:0] OC_SRC_HIT  = 2'd1;
	localparam logic [1:0] OC_DST_HIT  = 2'd2;
	localparam logic [1:0] OC_NO_HIT   = 2'd3;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] WAYS_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WR1,
		ST_WR2,
		ST_DONE
	} ctl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic wr_first;
		logic wr_second;
		logic load_out;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic scan_last;
		logic need_second;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/epc_ram.sv
// Generic single write port, single read port RAM with registered read.
module epc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/epc_ctrl.sv
// Controller state machine of the edge pair page cache.
module epc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  epc_pkg::dp_sts_t  sts,
	output epc_pkg::dp_cmd_t  cmd
);
	import epc_pkg::*;

	ctl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN: state_nx = ST_WR1;
			ST_WR1: begin
				state_nx = sts.need_second ? ST_WR2 : ST_DONE;
			end
			ST_WR2: state_nx = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_DRAIN: cmd = '0;
			ST_WR1:   cmd.wr_first = 1'b1;
			ST_WR2:   cmd.wr_second = 1'b1;
			ST_DONE:  cmd.load_out = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

FILE: hw/rtl/epc_dp.sv
// Datapath: tag store, slot scan, FIFO pointer, load counter, response register.
module epc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  epc_pkg::dp_cmd_t              cmd,
	output epc_pkg::dp_sts_t              sts,
	input  epc_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [epc_pkg::CFG_W-1:0]     cfg_wdata,
	output epc_pkg::rsp_t                 rsp,
	output logic                          rsp_valid,
	input  logic                          rsp_ready
);
	import epc_pkg::*;

	localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int CNT_W = $clog2(CACHE_SLOTS + 1);

	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p,
			input logic [CNT_W-1:0] w);
		logic [CNT_W:0] nx;
		nx = (CNT_W + 1)'(p) + (CNT_W + 1)'(1);
		return (nx >= (CNT_W + 1)'(w)) ? '0 : IDX_W'(nx);
	endfunction

	// Configuration and persistent state
	logic [CFG_W-1:0]       ways_q;
	logic [CACHE_SLOTS-1:0] slot_vld_q;
	logic [IDX_W-1:0]       fptr_q;
	logic [31:0]            tot_q;

	// Per-transaction work registers
	logic [CNT_W-1:0]       ways_cur_q;
	logic [PAGE_BITS-1:0]   src_q, dst_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   src_hit_q, dst_hit_q, psrc_q, pdst_q;
	rsp_t                   res_q;

	// Scan compare stage
	logic                   cmp_pend_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic                   cmp_vld_s1;

	logic [CNT_W-1:0]       ways_eff;
	logic [IDX_W-1:0]       ptr_norm;
	logic [PAGE_BITS-1:0]   rd_tag;
	logic                   m_src, m_dst;
	logic                   both_hit, one_hit, skip, load1, need2;
	logic [IDX_W-1:0]       ptr_a;
	logic [PAGE_BITS-1:0]   page1;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [PAGE_BITS-1:0]   ram_wdata;
	logic [31:0]            tot_inc;

	always_comb begin
		if (ways_q == '0) begin
			ways_eff = CNT_W'(1);
		end else if (32'(ways_q) > 32'(CACHE_SLOTS)) begin
			ways_eff = CNT_W'(CACHE_SLOTS);
		end else begin
			ways_eff = CNT_W'(ways_q);
		end
	end

	assign ptr_norm = (CNT_W'(fptr_q) >= ways_eff) ? '0 : fptr_q;

	assign m_src = cmp_vld_s1 && (rd_tag == src_q);
	assign m_dst = cmp_vld_s1 && (rd_tag == dst_q);

	assign both_hit = src_hit_q && dst_hit_q;
	assign one_hit  = src_hit_q ^ dst_hit_q;
	assign skip     = one_hit && (src_hit_q ? psrc_q : pdst_q);
	assign load1    = !both_hit;
	assign need2    = !src_hit_q && !dst_hit_q && (src_q != dst_q);
	assign ptr_a    = skip ? adv(fptr_q, ways_cur_q) : fptr_q;
	assign page1    = src_hit_q ? dst_q : src_q;
	assign tot_inc  = (tot_q == '1) ? tot_q : tot_q + 32'd1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_a;
		ram_wdata = page1;
		if (cmd.wr_first) begin
			ram_we = load1;
		end else if (cmd.wr_second) begin
			ram_we    = 1'b1;
			ram_waddr = fptr_q;
			ram_wdata = dst_q;
		end
	end

	epc_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(CACHE_SLOTS)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(rd_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q      <= WAYS_RESET;
			slot_vld_q  <= '0;
			fptr_q      <= '0;
			tot_q       <= '0;
			cmp_pend_s1 <= 1'b0;
			rsp_valid   <= 1'b0;
		end else begin
			if (cfg_we) ways_q <= cfg_wdata;
			cmp_pend_s1 <= cmd.scan_step;
			if (cmd.accept) begin
				fptr_q <= ptr_norm;
			end
			if (cmd.wr_first && load1) begin
				slot_vld_q[ptr_a] <= 1'b1;
				fptr_q            <= adv(ptr_a, ways_cur_q);
				tot_q             <= tot_inc;
			end
			if (cmd.wr_second) begin
				slot_vld_q[fptr_q] <= 1'b1;
				fptr_q             <= adv(fptr_q, ways_cur_q);
				tot_q              <= tot_inc;
			end
			if (cmd.load_out) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ways_cur_q <= ways_eff;
			src_q      <= PAGE_BITS'(req.src_page);
			dst_q      <= PAGE_BITS'(req.dst_page);
			idx_q      <= '0;
			src_hit_q  <= 1'b0;
			dst_hit_q  <= 1'b0;
			psrc_q     <= 1'b0;
			pdst_q     <= 1'b0;
		end
		if (cmd.scan_step) begin
			idx_q      <= idx_q + IDX_W'(1);
			cmp_idx_s1 <= idx_q;
			cmp_vld_s1 <= slot_vld_q[idx_q];
		end
		if (cmp_pend_s1) begin
			src_hit_q <= src_hit_q | m_src;
			dst_hit_q <= dst_hit_q | m_dst;
			if (cmp_idx_s1 == fptr_q) begin
				psrc_q <= m_src;
				pdst_q <= m_dst;
			end
		end
		if (cmd.wr_first) begin
			res_q.outcome      <= both_hit ? OC_BOTH_HIT :
				(src_hit_q ? OC_SRC_HIT : (dst_hit_q ? OC_DST_HIT : OC_NO_HIT));
			res_q.pages_loaded <= load1 ? 2'd1 : 2'd0;
			res_q.first_page   <= load1 ? page1 : '0;
			res_q.first_slot   <= load1 ? ptr_a : '0;
			res_q.second_page  <= '0;
			res_q.second_slot  <= '0;
			res_q.skipped      <= skip;
			res_q.total_loads  <= load1 ? tot_inc : tot_q;
		end
		if (cmd.wr_second) begin
			res_q.pages_loaded <= 2'd2;
			res_q.second_page  <= dst_q;
			res_q.second_slot  <= fptr_q;
			res_q.total_loads  <= tot_inc;
		end
		if (cmd.load_out) begin
			rsp <= res_q;
		end
	end

	assign sts.scan_last   = (CNT_W'(idx_q) + CNT_W'(1)) == ways_cur_q;
	assign sts.need_second = need2;
	assign sts.out_free    = !rsp_valid || rsp_ready;

endmodule

FILE: hw/rtl/edge_pair_page_cache_unit.sv
// Top level of the edge pair page cache: controller plus datapath.
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_ready   src_page, dst_page
//  rsp       out        rsp_valid/rsp_ready   outcome, loads, slots, skipped, total
//  cfg       in         cfg_we                ways_in_use (5 bits)
//
// One request transaction scans the slots in use, whose number is ways, then
// loads one page, or two, or none when both hit: the tag RAM has one read
// port, so the scan compares one slot per cycle against both pages.
// Reset clears the valid bits, FIFO pointer and load total at once; no
// clearing pass is needed. A stalled response holds in its output register
// while the next request is accepted; that request waits in its final cycle
// only if the previous response has still not been taken.
module edge_pair_page_cache_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  epc_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output epc_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [epc_pkg::CFG_W-1:0] cfg_wdata
);
	import epc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequence scan, writes and response hand-off.
	epc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold tags, pointer and totals; compare and load pages.
	epc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

FILE: verif/edge_pair_page_cache_unit_test.sv
// Self-checking testbench for the edge pair page cache: FIFO tag model, random edges and stalls.
import epc_pkg::*;

// Track the cache tags, predict each response transaction and check it on arrival.
class page_tag_scoreboard;
	localparam int RING_DEPTH = 64;

	bit [15:0]   slot_page [16];
	bit          slot_live [16];
	int          fill_ptr = 0;
	int          cur_ways = 16;
	bit [31:0]   load_count = '0;
	logic [4:0]  ways_reg = WAYS_RESET;
	rsp_t        expected_replies [RING_DEPTH];
	int          head_idx = 0;
	int          tail_idx = 0;
	int          errors = 0;
	int          outcome_tally [4];
	int          skip_tally = 0;

	function void set_ways(logic [4:0] v);
		ways_reg = v;
	endfunction

	// Responses predicted but not yet seen.
	function int outstanding();
		return tail_idx - head_idx;
	endfunction

	function bit holds(bit [15:0] pg);
		for (int i = 0; i < cur_ways; i++)
			if (slot_live[i] && slot_page[i] == pg)
				return 1'b1;
		return 1'b0;
	endfunction

	function int next_slot(int s);
		return (s + 1 >= cur_ways) ? 0 : s + 1;
	endfunction

	// Write a page at the FIFO pointer, advance the pointer, count the load.
	function bit [3:0] fill(bit [15:0] pg);
		int s;
		s = fill_ptr;
		slot_page[s] = pg;
		slot_live[s] = 1'b1;
		fill_ptr = next_slot(s);
		if (load_count != '1)
			load_count++;
		return s[3:0];
	endfunction

	function void note_access(req_t a);
		rsp_t      want;
		bit        src_in;
		bit        dst_in;
		bit [15:0] hit_pg;
		want = '0;
		cur_ways = (ways_reg == 0) ? 1 : (ways_reg > 16) ? 16 : int'(ways_reg);
		if (fill_ptr >= cur_ways)
			fill_ptr = 0;
		src_in = holds(a.src_page);
		dst_in = holds(a.dst_page);
		if (src_in && dst_in) begin
			want.outcome = OC_BOTH_HIT;
		end else if (src_in || dst_in) begin
			want.outcome = src_in ? OC_SRC_HIT : OC_DST_HIT;
			hit_pg = src_in ? a.src_page : a.dst_page;
			// step past the pointer slot once when it holds the page that hit
			if (slot_live[fill_ptr] && slot_page[fill_ptr] == hit_pg) begin
				fill_ptr = next_slot(fill_ptr);
				want.skipped = 1'b1;
			end
			want.first_page = src_in ? a.dst_page : a.src_page;
			want.first_slot = fill(want.first_page);
			want.pages_loaded = 2'd1;
		end else begin
			want.outcome = OC_NO_HIT;
			want.first_page = a.src_page;
			want.first_slot = fill(a.src_page);
			want.pages_loaded = 2'd1;
			if (a.dst_page != a.src_page) begin
				want.second_page = a.dst_page;
				want.second_slot = fill(a.dst_page);
				want.pages_loaded = 2'd2;
			end
		end
		want.total_loads = load_count;
		outcome_tally[want.outcome]++;
		skip_tally += want.skipped;
		expected_replies[tail_idx % RING_DEPTH] = want;
		tail_idx++;
	endfunction

	function void match_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			errors++;
		end
	endfunction

	function void check_reply(rsp_t got);
		rsp_t want;
		if (outstanding() == 0) begin
			$error("response transaction with no access outstanding: %p", got);
			errors++;
			return;
		end
		want = expected_replies[head_idx % RING_DEPTH];
		head_idx++;
		match_field("outcome", 32'(want.outcome), 32'(got.outcome));
		match_field("pages_loaded", 32'(want.pages_loaded), 32'(got.pages_loaded));
		match_field("first_page", 32'(want.first_page), 32'(got.first_page));
		match_field("first_slot", 32'(want.first_slot), 32'(got.first_slot));
		match_field("second_page", 32'(want.second_page), 32'(got.second_page));
		match_field("second_slot", 32'(want.second_slot), 32'(got.second_slot));
		match_field("skipped", 32'(want.skipped), 32'(got.skipped));
		match_field("total_loads", want.total_loads, got.total_loads);
	endfunction
endclass

module edge_pair_page_cache_unit_test;
	// Slowest legal run: about 1900 accesses, each at up to sixteen ways, plus
	// the idle gaps on the request side and the stalls on the response side,
	// plus the pauses around register writes; the limit allows several times
	// that.
	localparam int LIMIT_CYCLES     = 600000;
	localparam int RANDOM_PER_PHASE = 190;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	page_tag_scoreboard tags_sb;

	// Working set of pages for the random part, redrawn for every way setting.
	logic [15:0] page_pool [32];
	int          cycle_count = 0;

	// Idle pattern of each side: a run of items either without gaps or with
	// random gaps.
	int drv_left = 0;
	int rcv_left = 0;
	bit drv_calm;
	bit rcv_calm;

	// Way settings after reset: the single way, zero (treated as one), values
	// above the slot count (treated as sixteen), and lowering then raising
	// again so that slots left alone come back into the compare.
	logic [CFG_W-1:0] way_plan [10] = '{5'd1, 5'd0, 5'd2, 5'd4, 5'd31,
		5'd8, 5'd3, 5'd17, WAYS_RESET, 5'd5};

	edge_pair_page_cache_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int draw_gap(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(8, 60);
			calm = ($urandom_range(0, 3) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// Offer one edge access; hold valid and payload until the transaction is
	// taken, then note it so the expected response is queued.
	task automatic send_access(logic [15:0] src, logic [15:0] dst);
		req_t a;
		int   gap;
		a.src_page = src;
		a.dst_page = dst;
		gap = draw_gap(drv_left, drv_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= a;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		tags_sb.note_access(a);
	endtask

	// Write the way count only with the block idle: drain every outstanding
	// response, then let the last access finish its tail.
	task automatic write_ways(logic [CFG_W-1:0] v);
		req_valid <= 1'b0;
		while (tags_sb.outstanding() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		tags_sb.set_ways(v);
		cfg_we <= 1'b0;
	endtask

	// Response side: stall at random, check every transaction taken.
	initial begin
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap(rcv_left, rcv_calm);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			tags_sb.check_reply(rsp);
		end
	end

	initial begin
		logic [15:0] src;
		logic [15:0] dst;
		int          span;
		int          pick;
		int          eff;
		tags_sb = new;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= WAYS_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with sixteen ways from reset.
		// Both miss on the same page, at both ends of the page range.
		send_access(16'h0000, 16'h0000);
		send_access(16'hFFFF, 16'hFFFF);
		// Both hit.
		send_access(16'h0000, 16'hFFFF);
		// Both miss on different pages until the pointer wraps back to slot 0,
		// leaving page k in slot k for k = 2..15.
		for (int p = 2; p < 16; p += 2)
			send_access(16'(p), 16'(p + 1));
		// Source hit with the pointer slot holding that page: skip once.
		send_access(16'h0000, 16'd100);
		// Destination hit, pointer slot holds another page: no skip.
		send_access(16'd300, 16'd100);
		// Destination hit with the pointer slot holding that page: skip.
		send_access(16'd400, 16'd3);

		foreach (way_plan[i]) begin
			write_ways(way_plan[i]);
			eff = (way_plan[i] == 0) ? 1 : (way_plan[i] > 16) ? 16 : int'(way_plan[i]);
			// A single way: the skip wraps onto the same slot and overwrites it.
			if (way_plan[i] == 5'd1) begin
				send_access(16'h5A5A, 16'h5A5A);
				send_access(16'h5A5A, 16'hA5A5);
			end
			foreach (page_pool[k])
				page_pool[k] = 16'($urandom);
			// Keep the working set near the way count so hits, misses and
			// skips all show up.
			span = $urandom_range(eff, 2 * eff + 2);
			if (span > 32)
				span = 32;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				src  = page_pool[$urandom_range(0, span - 1)];
				dst  = page_pool[$urandom_range(0, span - 1)];
				pick = $urandom_range(0, 99);
				if (pick < 15)
					dst = src;
				else if (pick < 25)
					src = 16'($urandom);
				else if (pick < 35)
					dst = 16'($urandom);
				send_access(src, dst);
			end
		end

		// Drain, then watch a while longer for any stray response.
		req_valid <= 1'b0;
		while (tags_sb.outstanding() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Covered %0d edge accesses over %0d way settings, with gaps on both channels.",
			tags_sb.outcome_tally[0] + tags_sb.outcome_tally[1] +
			tags_sb.outcome_tally[2] + tags_sb.outcome_tally[3], $size(way_plan) + 1);
		$display("Outcomes: %0d both hit, %0d source only, %0d destination only, %0d both miss;",
			tags_sb.outcome_tally[OC_BOTH_HIT], tags_sb.outcome_tally[OC_SRC_HIT],
			tags_sb.outcome_tally[OC_DST_HIT], tags_sb.outcome_tally[OC_NO_HIT]);
		$display("%0d skips, %0d loads.", tags_sb.skip_tally, tags_sb.load_count);
		if (tags_sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/epc_pkg.sv
hw/rtl/epc_ram.sv
hw/rtl/epc_ctrl.sv
hw/rtl/epc_dp.sv
hw/rtl/edge_pair_page_cache_unit.sv
verif/edge_pair_page_cache_unit_test.sv
